// ===== src/persistence_minima_finder_unit_macros.svh =====
// Assertion macros used by the persistence minima finder engine (pmf_back).
`ifndef PERSISTENCE_MINIMA_FINDER_UNIT_MACROS_SVH
`define PERSISTENCE_MINIMA_FINDER_UNIT_MACROS_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define PMF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication
`define PMF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

// ===== src/pmf_pkg.sv =====
// Package: shared types and constants of the persistence minima finder.
`default_nettype none
package pmf_pkg;

  localparam int OUT_LIMIT = 32;
  localparam int OW        = $clog2(OUT_LIMIT);
  localparam int EW        = $clog2(OUT_LIMIT + 1);
  localparam int COST_W    = 16;
  localparam int IDX_W     = 6;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SORT_I,
    ST_SORT_J,
    ST_SORT_W,
    ST_SW_INIT,
    ST_SW_LAST,
    ST_SW_A,
    ST_SW_B,
    ST_SW_C,
    ST_SW_D,
    ST_SW_E,
    ST_SW_F,
    ST_PS_A,
    ST_PS_B,
    ST_PS_C,
    ST_RK_I,
    ST_RK_J,
    ST_RK_W,
    ST_EM_A,
    ST_EM_B,
    ST_EM_C,
    ST_EM_WAIT
  } pmf_state_e;

  typedef struct packed {
    logic [IDX_W-1:0]  birth_index;
    logic [IDX_W-1:0]  left_edge;
    logic [IDX_W-1:0]  right_edge;
    logic [IDX_W-1:0]  death_index;
    logic [COST_W-1:0] persistence;
    logic              last_peak;
  } pmf_result_t;

endpackage
`default_nettype wire

// ===== src/pmf_fifo.sv =====
// Two-entry queue carrying frame lengths from the loader to the engine.
`default_nettype none
module pmf_fifo #(
  parameter int W = 7
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] push_data_i,
  input  wire logic         pop_i,
  output logic              valid_o,
  output logic              full_o,
  output logic [W-1:0]      data_o
);
  logic [W-1:0] mem_q [2];
  logic         wp_q, wp_d, rp_q, rp_d;
  logic [1:0]   cnt_q, cnt_d;
  logic         do_push, do_pop;

  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wp_d  = do_push ? ~wp_q : wp_q;
    rp_d  = do_pop ? ~rp_q : rp_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wp_q] <= push_data_i;
    end
  end
endmodule
`default_nettype wire

// ===== src/pmf_front.sv =====
// Loader: accepts sample words, stores them and hands finished frames on.
`default_nettype none
module pmf_front #(
  parameter int MAX_SAMPLES = 64,
  parameter int IW = $clog2(MAX_SAMPLES),
  parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [15:0]          cost_i,
  input  wire logic                 last_sample_i,
  output logic                      wr_en_o,
  output logic [IW-1:0]             wr_addr_o,
  output logic [15:0]               wr_data_o,
  output logic                      push_o,
  output logic [CW-1:0]             push_n_o,
  input  wire logic                 fifo_full_i,
  input  wire logic                 frame_done_i
);
  logic [CW-1:0] cnt_q, cnt_d;
  logic          wait_q, wait_d;
  logic          accept, room;

  assign in_stall_o = wait_q || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign room       = (32'(cnt_q) < MAX_SAMPLES);
  assign wr_en_o    = accept && room;
  assign wr_addr_o  = IW'(cnt_q);
  assign wr_data_o  = cost_i;
  assign push_o     = accept && last_sample_i;
  assign push_n_o   = room ? cnt_q + CW'(1) : cnt_q;

  always_comb begin
    cnt_d  = cnt_q;
    wait_d = wait_q;
    if (frame_done_i) begin
      wait_d = 1'b0;
    end
    if (accept) begin
      if (last_sample_i) begin
        cnt_d  = '0;
        wait_d = 1'b1;
      end else if (room) begin
        cnt_d = cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      wait_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      wait_q <= wait_d;
    end
  end
endmodule
`default_nettype wire

// ===== src/pmf_back.sv =====
// Engine: cost sort, basin sweep, persistence ranking and result output.
`default_nettype none
`include "persistence_minima_finder_unit_macros.svh"
module pmf_back #(
  parameter int MAX_SAMPLES = 64,
  parameter int IW = $clog2(MAX_SAMPLES),
  parameter int CW = $clog2(MAX_SAMPLES + 1)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 wr_en_i,
  input  wire logic [IW-1:0]        wr_addr_i,
  input  wire logic [15:0]          wr_data_i,
  input  wire logic                 frame_valid_i,
  input  wire logic [CW-1:0]        frame_n_i,
  output logic                      frame_pop_o,
  output logic                      frame_done_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pmf_pkg::pmf_result_t      result_o
);
  import pmf_pkg::*;

  pmf_state_e state_q, state_d;

  logic [CW-1:0] n_q, n_d, i_q, i_d, j_q, j_d, jd_q, jd_d, cnt_q, cnt_d, bcnt_q, bcnt_d;
  logic          pv_q, pv_d;
  logic [IW-1:0] s_q, s_d, last_q, last_d, a2_q, a2_d, v2_q, v2_d;
  logic [EW-1:0] emitn_q, emitn_d;
  logic [MAX_SAMPLES-1:0] vis_q, vis_d;
  logic          out_valid_q, out_valid_d;
  pmf_result_t   res_q, res_d;

  // memories
  logic [15:0]   cost_mem [MAX_SAMPLES];
  logic [IW-1:0] so_mem [MAX_SAMPLES];
  logic [IW-1:0] st_mem [MAX_SAMPLES];
  logic [IW-1:0] bb_mem [MAX_SAMPLES];
  logic [IW-1:0] bl_mem [MAX_SAMPLES];
  logic [IW-1:0] br_mem [MAX_SAMPLES];
  logic [IW-1:0] bd_mem [MAX_SAMPLES];
  logic [15:0]   ps_mem [MAX_SAMPLES];
  logic [IW-1:0] or_mem [OUT_LIMIT];

  logic [IW-1:0] ca_addr, cb_addr, so_raddr, so_waddr, so_wdata;
  logic [IW-1:0] st_waddr, st_wdata, b_raddr, bl_raddr, br_raddr;
  logic [IW-1:0] bb_waddr, bl_waddr, br_waddr, bd_waddr;
  logic [IW-1:0] bb_wdata, bl_wdata, br_wdata, bd_wdata;
  logic [IW-1:0] pa_addr, pb_addr, ps_waddr, or_wdata;
  logic [OW-1:0] or_raddr, or_waddr;
  logic [15:0]   ps_wdata;
  logic          so_we, st_we, bb_we, bl_we, br_we, bd_we, ps_we, or_we;

  logic [15:0]   ca_rd_q, cb_rd_q, pa_rd_q, pb_rd_q;
  logic [IW-1:0] so_rd_q, stl_rd_q, str_rd_q, bb_rd_q, bl_rd_q, br_rd_q, bd_rd_q, or_rd_q;

  logic          lv, rv, hit_sort, hit_rank, accept_out, last_i, scan_end;
  logic [CW-1:0] lim;

  assign lv = (s_q != '0) && vis_q[IW'(s_q - IW'(1))];
  assign rv = ((CW'(s_q) + CW'(1)) < n_q) && vis_q[IW'(s_q + IW'(1))];
  assign hit_sort = (cb_rd_q < ca_rd_q) || ((cb_rd_q == ca_rd_q) && (jd_q < i_q));
  assign hit_rank = (pb_rd_q > pa_rd_q) || ((pb_rd_q == pa_rd_q) && (jd_q < i_q));
  assign accept_out = out_valid_q && !out_stall_i;
  assign lim = (state_q == ST_RK_J || state_q == ST_RK_W || state_q == ST_RK_I) ? bcnt_q : n_q;
  assign scan_end = pv_q && (j_q == lim);
  assign last_i = ((i_q + CW'(1)) == lim);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (frame_valid_i) state_d = ST_SORT_I;
      ST_SORT_I:  state_d = ST_SORT_J;
      ST_SORT_J:  if (scan_end) state_d = ST_SORT_W;
      ST_SORT_W:  state_d = last_i ? ST_SW_INIT : ST_SORT_I;
      ST_SW_INIT: state_d = ST_SW_LAST;
      ST_SW_LAST: state_d = ST_SW_A;
      ST_SW_A:    state_d = ST_SW_B;
      ST_SW_B:    state_d = ST_SW_C;
      ST_SW_C:    state_d = ST_SW_D;
      ST_SW_D:    state_d = ST_SW_E;
      ST_SW_E: begin
        if (lv && rv) state_d = ST_SW_F;
        else          state_d = last_i ? ST_PS_A : ST_SW_A;
      end
      ST_SW_F:    state_d = last_i ? ST_PS_A : ST_SW_A;
      ST_PS_A:    state_d = ST_PS_B;
      ST_PS_B:    state_d = ST_PS_C;
      ST_PS_C:    state_d = ((i_q + CW'(1)) == bcnt_q) ? ST_RK_I : ST_PS_A;
      ST_RK_I:    state_d = ST_RK_J;
      ST_RK_J:    if (scan_end) state_d = ST_RK_W;
      ST_RK_W:    state_d = last_i ? ST_EM_A : ST_RK_I;
      ST_EM_A:    state_d = ST_EM_B;
      ST_EM_B:    state_d = ST_EM_C;
      ST_EM_C:    state_d = ST_EM_WAIT;
      ST_EM_WAIT: begin
        if (accept_out) begin
          state_d = (32'(i_q) + 1 == 32'(emitn_q)) ? ST_IDLE : ST_EM_A;
        end
      end
      default:    state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    n_d = n_q;  i_d = i_q;  j_d = j_q;  jd_d = jd_q;  pv_d = pv_q;
    cnt_d = cnt_q;  bcnt_d = bcnt_q;  s_d = s_q;  last_d = last_q;
    a2_d = a2_q;  v2_d = v2_q;  emitn_d = emitn_q;  vis_d = vis_q;
    out_valid_d = out_valid_q;  res_d = res_q;
    frame_pop_o = 1'b0;  frame_done_o = 1'b0;
    ca_addr = IW'(i_q);  cb_addr = IW'(j_q);
    so_raddr = IW'(i_q);  so_we = 1'b0;  so_waddr = IW'(cnt_q);  so_wdata = IW'(i_q);
    st_we = 1'b0;  st_waddr = s_q;  st_wdata = IW'(bcnt_q);
    b_raddr = IW'(i_q);  bl_raddr = stl_rd_q;  br_raddr = str_rd_q;
    bb_we = 1'b0;  bl_we = 1'b0;  br_we = 1'b0;  bd_we = 1'b0;
    bb_waddr = IW'(bcnt_q);  bl_waddr = IW'(bcnt_q);
    br_waddr = IW'(bcnt_q);  bd_waddr = IW'(bcnt_q);
    bb_wdata = s_q;  bl_wdata = s_q;  br_wdata = s_q;  bd_wdata = s_q;
    pa_addr = IW'(i_q);  pb_addr = IW'(j_q);
    ps_we = 1'b0;  ps_waddr = IW'(i_q);
    ps_wdata = (ca_rd_q > cb_rd_q) ? ca_rd_q - cb_rd_q : cb_rd_q - ca_rd_q;
    or_we = 1'b0;  or_waddr = OW'(cnt_q);  or_wdata = IW'(i_q);  or_raddr = OW'(i_q);

    unique case (state_q)
      ST_IDLE: begin
        if (frame_valid_i) begin
          frame_pop_o = 1'b1;
          n_d    = frame_n_i;
          i_d    = '0;
          bcnt_d = '0;
        end
      end
      ST_SORT_I, ST_RK_I: begin
        j_d   = '0;
        pv_d  = 1'b0;
        cnt_d = '0;
      end
      ST_SORT_J, ST_RK_J: begin
        if (pv_q && ((state_q == ST_SORT_J) ? hit_sort : hit_rank)) begin
          cnt_d = cnt_q + CW'(1);
        end
        if (j_q != lim) begin
          jd_d = j_q;
          j_d  = j_q + CW'(1);
          pv_d = 1'b1;
        end else begin
          pv_d = 1'b0;
        end
      end
      ST_SORT_W: begin
        so_we = 1'b1;
        i_d   = last_i ? '0 : i_q + CW'(1);
      end
      ST_SW_INIT: so_raddr = IW'(n_q - CW'(1));
      ST_SW_LAST: last_d = so_rd_q;
      ST_SW_A:    ;
      ST_SW_B:    s_d = so_rd_q;
      ST_SW_C, ST_SW_D: ;
      ST_SW_E: begin
        st_we = 1'b1;
        vis_d[s_q] = 1'b1;
        if (!lv && !rv) begin
          bb_we = 1'b1;  bl_we = 1'b1;  br_we = 1'b1;  bd_we = 1'b1;
          bd_wdata = (bcnt_q == '0) ? last_q : s_q;
          bcnt_d = bcnt_q + CW'(1);
        end else if (lv && !rv) begin
          br_we = 1'b1;  br_waddr = stl_rd_q;
          st_wdata = stl_rd_q;
        end else if (!lv && rv) begin
          bl_we = 1'b1;  bl_waddr = str_rd_q;
          st_wdata = str_rd_q;
        end else if (stl_rd_q < str_rd_q) begin
          bd_we = 1'b1;  bd_waddr = str_rd_q;
          br_we = 1'b1;  br_waddr = stl_rd_q;  br_wdata = br_rd_q;
          st_wdata = stl_rd_q;
          a2_d = br_rd_q;  v2_d = stl_rd_q;
        end else begin
          bd_we = 1'b1;  bd_waddr = stl_rd_q;
          bl_we = 1'b1;  bl_waddr = str_rd_q;  bl_wdata = bl_rd_q;
          st_wdata = str_rd_q;
          a2_d = bl_rd_q;  v2_d = str_rd_q;
        end
        if (!(lv && rv)) begin
          i_d = last_i ? '0 : i_q + CW'(1);
        end
      end
      ST_SW_F: begin
        st_we = 1'b1;  st_waddr = a2_q;  st_wdata = v2_q;
        i_d = last_i ? '0 : i_q + CW'(1);
      end
      ST_PS_A: ;
      ST_PS_B: begin
        ca_addr = bb_rd_q;
        cb_addr = bd_rd_q;
      end
      ST_PS_C: begin
        ps_we = 1'b1;
        i_d = ((i_q + CW'(1)) == bcnt_q) ? '0 : i_q + CW'(1);
      end
      ST_RK_W: begin
        or_we = (32'(cnt_q) < OUT_LIMIT);
        emitn_d = (32'(bcnt_q) < OUT_LIMIT) ? EW'(bcnt_q) : EW'(OUT_LIMIT);
        i_d = last_i ? '0 : i_q + CW'(1);
      end
      ST_EM_A: ;
      ST_EM_B: begin
        b_raddr = or_rd_q;  bl_raddr = or_rd_q;  br_raddr = or_rd_q;
        pa_addr = or_rd_q;
      end
      ST_EM_C: begin
        out_valid_d       = 1'b1;
        res_d.birth_index = IDX_W'(bb_rd_q);
        res_d.left_edge   = IDX_W'(bl_rd_q);
        res_d.right_edge  = IDX_W'(br_rd_q);
        res_d.death_index = IDX_W'(bd_rd_q);
        res_d.persistence = pa_rd_q;
        res_d.last_peak   = (32'(i_q) + 1 == 32'(emitn_q));
      end
      ST_EM_WAIT: begin
        if (accept_out) begin
          out_valid_d = 1'b0;
          i_d = i_q + CW'(1);
          if (res_q.last_peak) begin
            frame_done_o = 1'b1;
            vis_d  = '0;
            bcnt_d = '0;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      jd_q        <= '0;
      pv_q        <= 1'b0;
      cnt_q       <= '0;
      bcnt_q      <= '0;
      emitn_q     <= '0;
      vis_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      jd_q        <= jd_d;
      pv_q        <= pv_d;
      cnt_q       <= cnt_d;
      bcnt_q      <= bcnt_d;
      emitn_q     <= emitn_d;
      vis_q       <= vis_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    last_q <= last_d;
    a2_q   <= a2_d;
    v2_q   <= v2_d;
    res_q  <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) cost_mem[wr_addr_i] <= wr_data_i;
    ca_rd_q <= cost_mem[ca_addr];
    cb_rd_q <= cost_mem[cb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (so_we) so_mem[so_waddr] <= so_wdata;
    so_rd_q <= so_mem[so_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (st_we) st_mem[st_waddr] <= st_wdata;
    stl_rd_q <= st_mem[IW'(s_q - IW'(1))];
    str_rd_q <= st_mem[IW'(s_q + IW'(1))];
  end

  always_ff @(posedge clk_i) begin
    if (bb_we) bb_mem[bb_waddr] <= bb_wdata;
    bb_rd_q <= bb_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bd_we) bd_mem[bd_waddr] <= bd_wdata;
    bd_rd_q <= bd_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bl_we) bl_mem[bl_waddr] <= bl_wdata;
    bl_rd_q <= bl_mem[bl_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (br_we) br_mem[br_waddr] <= br_wdata;
    br_rd_q <= br_mem[br_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (ps_we) ps_mem[ps_waddr] <= ps_wdata;
    pa_rd_q <= ps_mem[pa_addr];
    pb_rd_q <= ps_mem[pb_addr];
  end

  always_ff @(posedge clk_i) begin
    if (or_we) or_mem[or_waddr] <= or_wdata;
    or_rd_q <= or_mem[or_raddr];
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `PMF_ASSERT_NOW(a_out_only_in_wait, out_valid_q, state_q == ST_EM_WAIT)
  `PMF_ASSERT_NOW(a_basins_within_frame, state_q != ST_IDLE, bcnt_q <= n_q)
  `PMF_ASSERT_NEXT(a_last_word_ends_frame, accept_out && res_q.last_peak, state_q == ST_IDLE)
  `PMF_ASSERT_NOW(a_pop_only_idle, frame_pop_o, state_q == ST_IDLE && vis_q == '0)
endmodule
`default_nettype wire

// ===== src/persistence_minima_finder_unit.sv =====
// Top level: persistence minima finder, loader, frame queue and engine.
//
// Input channel: one word per cost sample (cost_i, last_sample_i), taken when
// in_valid_i is high and in_stall_o is low. last_sample_i closes the frame.
// Up to MAX_SAMPLES samples are stored; later ones are dropped, but a dropped
// word with last_sample_i still closes the frame.
// Loading takes one word per cycle while in_stall_o is low. After the closing
// word in_stall_o stays high until the frame's last result word has been taken.
// Processing time is set by the rank-count sort over the cost read stream,
// the sweep step through ST_SW_A to ST_SW_E (three dependent memory reads,
// plus ST_SW_F on a basin merge) and the basin ranking.
// Output channel: one word per basin, at most 32, in descending persistence;
// last_peak_o marks the final word. out_stall_i holds the word in the output
// register. Reset clears all control state; the stores hold no defined values.
`default_nettype none
module persistence_minima_finder_unit #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] cost_i,
  input  wire logic        last_sample_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [5:0]       birth_index_o,
  output logic [5:0]       left_edge_o,
  output logic [5:0]       right_edge_o,
  output logic [5:0]       death_index_o,
  output logic [15:0]      persistence_o,
  output logic             last_peak_o
);
  import pmf_pkg::*;

  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int CW = $clog2(MAX_SAMPLES + 1);

  logic          wr_en, push, pop, fifo_valid, fifo_full, frame_done;
  logic [IW-1:0] wr_addr;
  logic [15:0]   wr_data;
  logic [CW-1:0] push_n, frame_n;
  pmf_result_t   result;

  pmf_front #(.MAX_SAMPLES(MAX_SAMPLES), .IW(IW), .CW(CW)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .cost_i, .last_sample_i,
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .push_o(push), .push_n_o(push_n),
    .fifo_full_i(fifo_full), .frame_done_i(frame_done)
  );

  pmf_fifo #(.W(CW)) u_fifo (
    .clk_i, .rst_ni,
    .push_i(push), .push_data_i(push_n), .pop_i(pop),
    .valid_o(fifo_valid), .full_o(fifo_full), .data_o(frame_n)
  );

  pmf_back #(.MAX_SAMPLES(MAX_SAMPLES), .IW(IW), .CW(CW)) u_back (
    .clk_i, .rst_ni,
    .wr_en_i(wr_en), .wr_addr_i(wr_addr), .wr_data_i(wr_data),
    .frame_valid_i(fifo_valid), .frame_n_i(frame_n), .frame_pop_o(pop),
    .frame_done_o(frame_done),
    .out_valid_o, .out_stall_i, .result_o(result)
  );

  assign birth_index_o = result.birth_index;
  assign left_edge_o   = result.left_edge;
  assign right_edge_o  = result.right_edge;
  assign death_index_o = result.death_index;
  assign persistence_o = result.persistence;
  assign last_peak_o   = result.last_peak;
endmodule
`default_nettype wire

// ===== verif/persistence_minima_finder_unit_tb.sv =====
// Testbench: random and directed cost frames checked against a predicted basin list.
`default_nettype none
module persistence_minima_finder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmf_pkg::*;

  localparam int CAP = 64;
  localparam int QUIET_AFTER = 330;

  typedef struct {
    logic [15:0] cost;
    logic        last;
    int          drain_to;
  } sample_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] cost_i = '0;
  logic last_sample_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [5:0] birth_index_o, left_edge_o, right_edge_o, death_index_o;
  logic [15:0] persistence_o;
  logic last_peak_o;

  sample_word_t pending_words[$];
  pmf_result_t  expected_basins[$];
  int basins_predicted = 0;
  int basins_seen = 0;
  int words_taken = 0;
  int errors = 0;
  int in_gap = 0;
  int out_gap = 0;
  logic [15:0] frame_costs[$];

  persistence_minima_finder_unit #(.MAX_SAMPLES(CAP)) u_top (.*);

  always #1 clk_i = ~clk_i;

  function automatic logic [15:0] absdiff(logic [15:0] a, logic [15:0] b);
    return a > b ? a - b : b - a;
  endfunction

  // walks samples in ascending cost, grows and joins basins, ranks by persistence
  task automatic predict_basins(input logic [15:0] c[$]);
    int n, nb, i, j, k, s, bl, br, v, emit;
    int order[CAP];
    int owner[CAP];
    bit seen[CAP];
    int b_birth[CAP], b_left[CAP], b_right[CAP], b_death[CAP];
    int rank[CAP];
    logic [15:0] pers[CAP];
    bit lv, rv;
    pmf_result_t r;
    n = c.size();
    nb = 0;
    for (i = 0; i < CAP; i++) seen[i] = 0;
    for (i = 0; i < n; i++) begin
      j = i;
      while (j > 0 && c[order[j-1]] > c[i]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (k = 0; k < n; k++) begin
      s = order[k];
      lv = s > 0 && seen[s-1];
      rv = s + 1 < n && seen[s+1];
      if (!lv && !rv) begin
        b_birth[nb] = s; b_left[nb] = s; b_right[nb] = s;
        b_death[nb] = (nb == 0) ? order[n-1] : s;
        owner[s] = nb;
        nb++;
      end else if (lv && !rv) begin
        bl = owner[s-1];
        b_right[bl] = s;
        owner[s] = bl;
      end else if (!lv && rv) begin
        br = owner[s+1];
        b_left[br] = s;
        owner[s] = br;
      end else begin
        bl = owner[s-1];
        br = owner[s+1];
        if (bl < br) begin
          b_death[br] = s;
          b_right[bl] = b_right[br];
          owner[s] = bl;
          owner[b_right[bl]] = bl;
        end else begin
          b_death[bl] = s;
          b_left[br] = b_left[bl];
          owner[s] = br;
          owner[b_left[br]] = br;
        end
      end
      seen[s] = 1;
    end
    for (i = 0; i < nb; i++) pers[i] = absdiff(c[b_birth[i]], c[b_death[i]]);
    for (i = 0; i < nb; i++) begin
      j = i;
      while (j > 0 && pers[rank[j-1]] < pers[i]) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    emit = nb < OUT_LIMIT ? nb : OUT_LIMIT;
    for (i = 0; i < emit; i++) begin
      v = rank[i];
      r.birth_index = b_birth[v][5:0];
      r.left_edge   = b_left[v][5:0];
      r.right_edge  = b_right[v][5:0];
      r.death_index = b_death[v][5:0];
      r.persistence = pers[v];
      r.last_peak   = (i + 1 == emit);
      expected_basins.push_back(r);
    end
    basins_predicted += emit;
  endtask

  task automatic queue_sample(input logic [15:0] c, input logic last, input bit drain);
    sample_word_t w;
    w.cost = c;
    w.last = last;
    w.drain_to = drain ? basins_predicted : 0;
    pending_words.push_back(w);
    if (frame_costs.size() < CAP) frame_costs.push_back(c);
    if (last) begin
      predict_basins(frame_costs);
      frame_costs.delete();
    end
  endtask

  task automatic queue_frame(input logic [15:0] c[$], input bit drain);
    foreach (c[i]) queue_sample(c[i], i == c.size() - 1, drain && i == 0);
  endtask

  function automatic logic [15:0] rand_cost(int mode);
    case (mode)
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 40));
      2: return $urandom_range(0, 1) ? 16'hFFFF - 16'($urandom_range(0, 2)) : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on basin %0d: %s got %0d want %0d", basins_seen, what, got, want);
    errors++;
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) words_taken <= words_taken + 1;
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0 &&
                     basins_seen >= pending_words[0].drain_to) begin
          if (words_taken < QUIET_AFTER && $urandom_range(0, 9) == 0) begin
            in_gap <= $urandom_range(1, 13) - 1;
            in_valid_i <= 1'b0;
          end else begin
            sample_word_t w;
            w = pending_words.pop_front();
            cost_i <= w.cost;
            last_sample_i <= w.last;
            in_valid_i <= 1'b1;
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side stall and checking
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_basins.size() == 0) begin
          report_mismatch("unexpected word, birth_index", birth_index_o, 0);
        end else begin
          pmf_result_t e;
          e = expected_basins.pop_front();
          if (birth_index_o !== e.birth_index)
            report_mismatch("birth_index", birth_index_o, e.birth_index);
          if (left_edge_o !== e.left_edge)
            report_mismatch("left_edge", left_edge_o, e.left_edge);
          if (right_edge_o !== e.right_edge)
            report_mismatch("right_edge", right_edge_o, e.right_edge);
          if (death_index_o !== e.death_index)
            report_mismatch("death_index", death_index_o, e.death_index);
          if (persistence_o !== e.persistence)
            report_mismatch("persistence", persistence_o, e.persistence);
          if (last_peak_o !== e.last_peak)
            report_mismatch("last_peak", last_peak_o, e.last_peak);
        end
        basins_seen <= basins_seen + 1;
      end
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (words_taken < QUIET_AFTER && $urandom_range(0, 7) == 0) begin
        out_gap <= $urandom_range(1, 13) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    logic [15:0] f[$];
    int len, mode, total;
    f = '{16'd5};
    queue_frame(f, 0);
    f = '{16'h0000, 16'hFFFF, 16'h0000};
    queue_frame(f, 0);
    f = '{16'd7, 16'd7, 16'd7, 16'd7};
    queue_frame(f, 1);
    f = '{16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000};
    queue_frame(f, 0);
    f = '{16'd4, 16'd3, 16'd2, 16'd1, 16'd9};
    queue_frame(f, 0);
    total = pending_words.size();
    while (total < 400) begin
      f.delete();
      case ($urandom_range(0, 19))
        0: len = $urandom_range(60, 70);
        1: len = 64;
        default: len = $urandom_range(1, 12);
      endcase
      mode = $urandom_range(0, 3);
      repeat (len) f.push_back(rand_cost(mode));
      queue_frame(f, $urandom_range(0, 15) == 0);
      total += len;
    end
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_words.size() == 0 && !in_valid_i && basins_seen == basins_predicted);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_basins.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== persistence_minima_finder_unit.f =====
+incdir+src
src/pmf_pkg.sv
src/pmf_fifo.sv
src/pmf_front.sv
src/pmf_back.sv
src/persistence_minima_finder_unit.sv
verif/persistence_minima_finder_unit_tb.sv
